### hdl/remb_pkg.sv
// ----------------------------------------------------------------------------
// remb_pkg
// Shared types and constants for the REMB feedback packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package remb_pkg;

  localparam logic [31:0] REMB_ID      = 32'h5245_4D42;
  localparam int          COUNT_LSB    = 24;
  localparam int          EXP_LSB      = 18;
  localparam int          MANT_W       = 18;
  localparam int          EXP_W        = 6;
  localparam int          RATE_W       = 64;
  localparam int          POS_W        = 9;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam int          QDEPTH_DEF   = 4;

  // Word positions inside the packet
  localparam logic [POS_W-1:0] POS_HDR   = 9'd0;
  localparam logic [POS_W-1:0] POS_IDENT = 9'd3;
  localparam logic [POS_W-1:0] POS_FCI   = 9'd4;
  localparam logic [POS_W-1:0] POS_LIST  = 9'd5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_IDENT    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  localparam logic KIND_SSRC    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One queued command: what the back end has to emit for one word
  typedef struct packed {
    logic              emit_ssrc;
    logic              emit_sum;
    logic [31:0]       ssrc;
    logic [RATE_W-1:0] rate;
    status_t           status;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/remb_if.sv
// ----------------------------------------------------------------------------
// remb_if
// Valid/ready channels: packet words in, parsed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface remb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface remb_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] ssrc;
  logic [63:0] bitrate;
  logic [2:0]  status;
  logic        end_of_run;

  modport source (output valid, output kind, output ssrc, output bitrate,
                  output status, output end_of_run, input ready);
  modport sink   (input valid, input kind, input ssrc, input bitrate,
                  input status, input end_of_run, output ready);
endinterface

`default_nettype wire

### hdl/remb_front.sv
// ----------------------------------------------------------------------------
// remb_front
// Accepts packet words, tracks packet state and queues emit commands.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_front
  import remb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  remb_in_if.sink     in_ch,
  input  wire logic   full,
  output logic        push,
  output cmd_t        cmd
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       announced_r, announced_nxt;
  logic [7:0]        total_r, total_nxt;
  status_t           status_r, status_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  logic              accept;
  logic [7:0]        cnt;
  logic [EXP_W-1:0]  expo;
  logic [MANT_W-1:0] mant;
  logic [RATE_W+MANT_W-1:0] shl;
  logic              lost;
  status_t           sum_status;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  assign cnt  = in_ch.word[COUNT_LSB +: 8];
  assign expo = in_ch.word[EXP_LSB +: EXP_W];
  assign mant = in_ch.word[MANT_W-1:0];
  assign shl  = {{RATE_W{1'b0}}, mant} << expo;
  assign lost = |shl[RATE_W +: MANT_W];

  always_comb begin
    announced_nxt = announced_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    rate_nxt      = rate_r;
    cmd           = '0;
    sum_status    = ST_OK;

    if (pos_r == POS_HDR) begin
      announced_nxt = in_ch.word[15:0];
    end else if (pos_r == POS_IDENT) begin
      status_nxt = (in_ch.word != REMB_ID) ? ST_IDENT : ST_OK;
    end else if (pos_r == POS_FCI) begin
      total_nxt = cnt;
      rate_nxt  = '0;
      priority if (announced_r != (16'd4 + {8'd0, cnt})) begin
        status_nxt = ST_LENGTH;
      end else if (status_r == ST_IDENT) begin
        status_nxt = ST_IDENT;
      end else if (lost) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        status_nxt = ST_OK;
        rate_nxt   = shl[RATE_W-1:0];
      end
    end else if (pos_r >= POS_LIST
                 && {1'b0, pos_r} < (10'd5 + {2'd0, total_r})
                 && status_r == ST_OK) begin
      cmd.emit_ssrc = 1'b1;
      cmd.ssrc      = in_ch.word;
    end

    if (in_ch.last) begin
      cmd.emit_sum = 1'b1;
      if (pos_r < POS_FCI) begin
        sum_status = ST_SHORT;
      end else if (status_nxt == ST_OK
                   && {1'b0, pos_r} < (10'd4 + {2'd0, total_nxt})) begin
        sum_status = ST_TRUNC;
      end else begin
        sum_status = status_nxt;
      end
      cmd.status = sum_status;
      cmd.rate   = (sum_status == ST_OK || sum_status == ST_TRUNC) ? rate_nxt : '0;
    end
  end

  assign push = accept && (cmd.emit_ssrc || cmd.emit_sum);

  always_comb begin
    if (in_ch.last) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      announced_r <= '0;
      total_r     <= '0;
      status_r    <= ST_OK;
      rate_r      <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      if (in_ch.last) begin
        // packet done: back to a clean state
        announced_r <= '0;
        total_r     <= '0;
        status_r    <= ST_OK;
        rate_r      <= '0;
      end else begin
        announced_r <= announced_nxt;
        total_r     <= total_nxt;
        status_r    <= status_nxt;
        rate_r      <= rate_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/remb_queue.sv
// ----------------------------------------------------------------------------
// remb_queue
// Short register FIFO of emit commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_queue
  import remb_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wr_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/remb_back.sv
// ----------------------------------------------------------------------------
// remb_back
// Expands queued commands into result transactions behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_back
  import remb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cmd_t      head,
  input  wire logic empty,
  output logic      pop,
  remb_out_if.source out_ch
);

  logic        load;
  logic        phase_r, phase_nxt;   // 1: entry of the head command already sent
  logic        valid_r;
  logic        kind_r, kind_nxt;
  logic [31:0] ssrc_r, ssrc_nxt;
  logic [63:0] rate_r, rate_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        eor_r, eor_nxt;

  assign load = !valid_r || out_ch.ready;

  always_comb begin
    pop        = 1'b0;
    phase_nxt  = phase_r;
    kind_nxt   = KIND_SUMMARY;
    ssrc_nxt   = '0;
    rate_nxt   = head.rate;
    status_nxt = head.status;
    eor_nxt    = 1'b1;
    if (head.emit_ssrc && !phase_r) begin
      kind_nxt   = KIND_SSRC;
      ssrc_nxt   = head.ssrc;
      rate_nxt   = '0;
      status_nxt = ST_OK;
      eor_nxt    = !head.emit_sum;
    end
    if (load && !empty) begin
      if (head.emit_ssrc && !phase_r && head.emit_sum) begin
        phase_nxt = 1'b1;
      end else begin
        pop       = 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= !empty;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      kind_r   <= kind_nxt;
      ssrc_r   <= ssrc_nxt;
      rate_r   <= rate_nxt;
      status_r <= status_nxt;
      eor_r    <= eor_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.ssrc       = ssrc_r;
  assign out_ch.bitrate    = rate_r;
  assign out_ch.status     = status_r;
  assign out_ch.end_of_run = eor_r;

endmodule

`default_nettype wire

### hdl/remb_feedback_parser.sv
// ----------------------------------------------------------------------------
// remb_feedback_parser
// Streaming parser for RTCP REMB feedback packets, one word per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the packet as big-endian 32-bit words, header first, with
//   last set on the final word. out_ch carries results: one SSRC entry per
//   listed SSRC of a valid packet, then one summary (status, bitrate) on the
//   last word, always flagged end_of_run.
// Throughput: one input word per cycle while the command queue is not full.
//   Per-word classification is combinational in the front end; the back end
//   sends one result per cycle while out_ch.ready is high, so a last word
//   that also carries an SSRC yields its entry first, then the summary.
// Path: a taken word is written into the command queue, then its result is
//   loaded into the output register and shown on out_ch.
// Stalls: the command queue (QDEPTH entries) absorbs output back-pressure;
//   in_ch.ready drops only once the queue is full. A held result keeps its
//   payload stable until taken.
// Reset: synchronous, active low; packet state returns to word 0, the queue
//   empties and out_ch.valid drops.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_feedback_parser
  import remb_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
)(
  input  wire logic   clk,
  input  wire logic   rst_n,
  remb_in_if.sink     in_ch,
  remb_out_if.source  out_ch
);

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push, pop, q_empty, q_full;

  // Front end: word counting, header/identifier/FCI checks, command build
  remb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .full  (q_full),
    .push  (push),
    .cmd   (push_cmd)
  );

  // Decouples input acceptance from output back-pressure
  remb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .head   (head_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  // Back end: one or two result transactions per command
  remb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_cmd),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### hdl/remb_checker.sv
// ----------------------------------------------------------------------------
// remb_checker
// Port-level assertions for the REMB feedback parser.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_checker
  import remb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [31:0] out_ssrc,
  input wire logic [63:0] out_bitrate,
  input wire logic [2:0]  out_status,
  input wire logic        out_end_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_ssrc) && $stable(out_bitrate) && $stable(out_status)
      && $stable(out_end_of_run))
    else $error("result changed while stalled");

  a_summary_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_end_of_run && out_ssrc == '0)
    else $error("summary without end_of_run or with ssrc");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SSRC |-> out_bitrate == '0 && out_status == ST_OK)
    else $error("entry carries rate or status");

  a_rate_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY && out_status != ST_OK
      && out_status != ST_TRUNC |-> out_bitrate == '0)
    else $error("bitrate reported on failed packet");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_TRUNC)
    else $error("status code out of range");

endmodule

bind remb_feedback_parser remb_checker u_remb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_ssrc       (out_ch.ssrc),
  .out_bitrate    (out_ch.bitrate),
  .out_status     (out_ch.status),
  .out_end_of_run (out_ch.end_of_run)
);

`default_nettype wire

### sim/remb_checker.sv
// ----------------------------------------------------------------------------
// remb_tb_checker
// Watches both channels of the REMB parser, predicts every result from the
// accepted packet words and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module remb_tb_checker
  import remb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_word,
  input  wire logic        in_last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_kind,
  input  wire logic [31:0] out_ssrc,
  input  wire logic [63:0] out_bitrate,
  input  wire logic [2:0]  out_status,
  input  wire logic        out_end_of_run,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic        kind;
    logic [31:0] ssrc;
    logic [63:0] bitrate;
    status_t     status;
    logic        end_of_run;
  } parsed_t;

  parsed_t parsed_q[$];
  int      errors = 0;

  // packet state, mirrors the parser
  logic [POS_W-1:0] word_pos  = '0;
  logic [15:0]      hdr_len   = '0;
  logic [7:0]       list_cnt  = '0;
  status_t          pkt_st    = ST_OK;
  logic [63:0]      pkt_rate  = '0;

  task automatic clear_packet();
    word_pos = '0;
    hdr_len  = '0;
    list_cnt = '0;
    pkt_st   = ST_OK;
    pkt_rate = '0;
  endtask

  task automatic push_parsed(input logic kind, input logic [31:0] ssrc,
                             input logic [63:0] rate, input status_t st,
                             input logic eor);
    parsed_t r;
    r.kind       = kind;
    r.ssrc       = ssrc;
    r.bitrate    = rate;
    r.status     = st;
    r.end_of_run = eor;
    parsed_q = {parsed_q, r};
  endtask

  task automatic parse_word(input logic [31:0] w, input logic last);
    logic [POS_W-1:0] p;
    logic [7:0]       cnt;
    logic [5:0]       e;
    logic [63:0]      m;
    logic [63:0]      r;
    status_t          st;
    p = word_pos;
    if (p == POS_HDR) begin
      hdr_len = w[15:0];
    end else if (p == POS_IDENT) begin
      pkt_st = (w != REMB_ID) ? ST_IDENT : ST_OK;
    end else if (p == POS_FCI) begin
      cnt      = w[31:COUNT_LSB];
      e        = w[EXP_LSB +: EXP_W];
      m        = {46'd0, w[MANT_W-1:0]};
      r        = m << e;
      list_cnt = cnt;
      pkt_rate = '0;
      if (int'(hdr_len) != 4 + int'(cnt)) begin
        pkt_st = ST_LENGTH;
      end else if (pkt_st == ST_IDENT) begin
        // identifier error stands
      end else if ((r >> e) != m) begin
        pkt_st = ST_OVERFLOW;
      end else begin
        pkt_st   = ST_OK;
        pkt_rate = r;
      end
    end else if (p >= POS_LIST && int'(p) < int'(POS_LIST) + int'(list_cnt) &&
                 pkt_st == ST_OK) begin
      push_parsed(KIND_SSRC, w, '0, ST_OK, !last);
    end

    if (last) begin
      if (p < POS_FCI) begin
        st = ST_SHORT;
      end else begin
        st = pkt_st;
        if (st == ST_OK && int'(p) < int'(POS_FCI) + int'(list_cnt)) st = ST_TRUNC;
      end
      push_parsed(KIND_SUMMARY, '0, (st == ST_OK || st == ST_TRUNC) ? pkt_rate : '0,
                  st, 1'b1);
      clear_packet();
    end else if (word_pos < POS_MAX) begin
      word_pos = p + 1'b1;
    end
  endtask

  task automatic compare_result();
    parsed_t x;
    if (parsed_q.size() == 0) begin
      $error("unexpected result: kind %0d ssrc %h bitrate %h status %0d",
             out_kind, out_ssrc, out_bitrate, out_status);
      errors++;
    end else begin
      x = parsed_q.pop_front();
      if (out_kind !== x.kind) begin
        $error("kind mismatch: expected %0d, got %0d", x.kind, out_kind);
        errors++;
      end
      if (out_ssrc !== x.ssrc) begin
        $error("ssrc mismatch: expected %h, got %h", x.ssrc, out_ssrc);
        errors++;
      end
      if (out_bitrate !== x.bitrate) begin
        $error("bitrate mismatch: expected %h, got %h", x.bitrate, out_bitrate);
        errors++;
      end
      if (out_status !== x.status) begin
        $error("status mismatch: expected %0d, got %0d", x.status, out_status);
        errors++;
      end
      if (out_end_of_run !== x.end_of_run) begin
        $error("end_of_run mismatch: expected %0d, got %0d", x.end_of_run,
               out_end_of_run);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_packet();
      parsed_q.delete();
    end else begin
      if (in_valid && in_ready) parse_word(in_word, in_last);
      if (out_valid && out_ready) compare_result();
    end
    fail_count <= errors;
    pending    <= parsed_q.size();
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the REMB feedback packet parser: directed packets
// for each status and edge case, then random packets with random link gaps
// and output back-pressure. Checking happens in remb_tb_checker and the bound remb_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import remb_pkg::*;

  // Worst correct run is roughly 1600 words, each after the longest link gap and
  // with two results each held off by a long stall; LIMIT allows about four times that.
  localparam int LIMIT     = 1_000_000;
  localparam int NUM_WORDS = 1000;
  localparam int DRAIN     = 16;   // leave slack after the last predicted result

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  remb_in_if  in_ch ();
  remb_out_if out_ch ();

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int words_sent = 0;
  int ready_hold = 0;
  bit burst;                  // no gaps inside the current packet

  logic [31:0] pkt_q[$];      // words of the packet being built

  remb_feedback_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  remb_tb_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_word        (in_ch.word),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_ssrc       (out_ch.ssrc),
    .out_bitrate    (out_ch.bitrate),
    .out_status     (out_ch.status),
    .out_end_of_run (out_ch.end_of_run),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("FAIL");
    $finish;
  end

  // Known values on every block input from time zero
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.word   = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Output back-pressure. Ready alternates between high runs and stalls.
  // One stall in ten is a long one; some high runs are long enough that whole
  // packets go through with no stall at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 10);
    end
  end

  // Idle cycles before a word: mostly none or short, a few long
  function automatic int link_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] fci_word(input int cnt, input int e, input int m);
    return {cnt[7:0], e[5:0], m[17:0]};
  endfunction

  // Entered and left at a falling edge. Valid stays high across back-to-back
  // words, so it is never dropped and raised in the same step.
  task automatic send_word(input logic [31:0] w, input logic last, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word  <= w;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_word(pkt_q[i], i == pkt_q.size() - 1, link_gap());
    pkt_q.delete();
  endtask

  // Header, sender SSRC, media SSRC, identifier, FCI word
  task automatic start_packet(input logic [31:0] hdr, input logic [31:0] ident,
                              input logic [31:0] fci);
    pkt_q.delete();
    pkt_q = {pkt_q, hdr};
    pkt_q = {pkt_q, 32'($urandom())};
    pkt_q = {pkt_q, 32'($urandom())};
    pkt_q = {pkt_q, ident};
    pkt_q = {pkt_q, fci};
  endtask

  task automatic add_words(input int n);
    repeat (n) pkt_q = {pkt_q, 32'($urandom())};
  endtask

  function automatic int ssrc_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(5, 20);
    return $urandom_range(21, 255);
  endfunction

  // --------------------------------------------------------------------------
  // Random packet. Most are well formed (sometimes cut short or padded with
  // trailing words) so the SSRC list gets exercised; the rest are too short,
  // carry a bad length or identifier, overflow the bitrate, or are noise.
  // A long packet walks the word position up to its ceiling.
  // --------------------------------------------------------------------------
  task automatic random_packet(input bit long_pkt);
    int          sel;
    int          cnt;
    int          e;
    int          m;
    int          n;
    logic [15:0] len;
    logic [31:0] ident;
    sel   = long_pkt ? 100 : $urandom_range(0, 99);
    cnt   = long_pkt ? 255 : ssrc_count();
    e     = $urandom_range(0, 46);
    m     = $urandom_range(0, 18'h3FFFF);
    len   = 16'(4 + cnt);
    ident = REMB_ID;
    burst = ($urandom_range(0, 3) == 0);

    if (sel >= 60 && sel < 68) begin
      // too short: cut below the FCI word
      start_packet({16'($urandom()), len}, ident, fci_word(cnt, e, m));
      n = $urandom_range(1, 4);
      while (pkt_q.size() > n) void'(pkt_q.pop_back());
      send_packet();
      return;
    end
    if (sel >= 92 && sel < 100) begin
      pkt_q.delete();
      add_words($urandom_range(1, 8));
      send_packet();
      return;
    end

    if (sel >= 68 && sel < 76) begin
      // length field off by one half the time, otherwise anything
      if ($urandom_range(0, 1)) len = $urandom_range(0, 1) ? len + 1'b1 : len - 1'b1;
      else len = 16'($urandom());
      if (len == 16'(4 + cnt)) len = len + 1'b1;
      if ($urandom_range(0, 3) == 0) ident = $urandom();
    end else if (sel >= 76 && sel < 84) begin
      ident = $urandom_range(0, 1) ? REMB_ID ^ (32'd1 << $urandom_range(0, 31))
                                   : $urandom();
    end else if (sel >= 84 && sel < 92) begin
      // mantissa top bit set with exponent >= 47 always loses bits
      e = $urandom_range(47, 63);
      m = $urandom_range(1, 18'h3FFFF) | 18'h20000;
    end else if (sel < 60 && $urandom_range(0, 9) == 0) begin
      // exponent past the fit window but zero mantissa: still valid
      e = $urandom_range(47, 63);
      m = 0;
    end

    start_packet({16'($urandom()), len}, ident, fci_word(cnt, e, m));
    add_words(cnt);
    if (long_pkt) begin
      add_words(530 - pkt_q.size());
    end else begin
      n = $urandom_range(0, 9);
      if (n == 0 && cnt > 0) begin
        // ends before the announced list is complete
        n = $urandom_range(5, 4 + cnt);
        while (pkt_q.size() > n) void'(pkt_q.pop_back());
      end else if (n == 1) begin
        add_words($urandom_range(1, 5));
      end
    end
    send_packet();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pkt_no;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed packets, sent back to back
    burst = 1'b1;

    // one word only, all ones: too short
    pkt_q = {pkt_q, 32'hFFFF_FFFF};
    send_packet();

    // valid, empty list, largest mantissa at the largest exponent that fits
    start_packet(32'h0000_0004, REMB_ID, fci_word(0, 46, 18'h3FFFF));
    send_packet();

    // largest exponent and mantissa: bitrate overflow
    start_packet(32'h0000_0004, REMB_ID, fci_word(0, 63, 18'h3FFFF));
    send_packet();

    // all-ones header and FCI, zero identifier: length check wins
    start_packet(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_packet();

    // identifier off by one bit; its SSRC must not come out
    start_packet(32'h0000_0005, REMB_ID ^ 32'd1, fci_word(1, 0, 0));
    pkt_q = {pkt_q, 32'hFFFF_FFFF};
    send_packet();

    // two SSRCs announced, one sent: entry, then truncated summary
    start_packet(32'h0000_0006, REMB_ID, fci_word(2, 0, 0));
    pkt_q = {pkt_q, 32'h0000_0000};
    send_packet();

    // Random packets; one long packet is forced partway through
    pkt_no = 0;
    while (words_sent < NUM_WORDS) begin
      random_packet(pkt_no == 40);
      pkt_no++;
    end
    in_ch.valid <= 1'b0;
    in_ch.last  <= 1'b0;

    // Drain: wait for every predicted result, then a few more cycles to
    // catch anything extra the block might still emit.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/remb_pkg.sv
hdl/remb_if.sv
hdl/remb_front.sv
hdl/remb_queue.sv
hdl/remb_back.sv
hdl/remb_feedback_parser.sv
hdl/remb_checker.sv
sim/remb_checker.sv
sim/tb_top.sv
